### sv/maf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_pkg - moving average filter shared types
// sample and register widths and the sequencer state type
// ----------------------------------------------------------------------------
package maf_pkg;

    localparam int SAMPLE_W = 16;   // width of sample and mean
    localparam int CFG_W    = 7;    // width of the window length register write

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [CFG_W-1:0]           t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

### sv/maf_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_sample_if - sample request channel
// valid/ready channel carrying one signed input sample
// ----------------------------------------------------------------------------
interface maf_sample_if import maf_pkg::*;;
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### sv/maf_mean_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_mean_if - mean request channel
// valid/ready channel carrying one signed window mean
// ----------------------------------------------------------------------------
interface maf_mean_if import maf_pkg::*;;
    logic    valid;
    logic    ready;
    t_sample mean;

    modport source (output valid, output mean, input ready);
    modport sink   (input valid, input mean, output ready);
endinterface

### sv/maf_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_cfg_if - configuration write channel
// valid/ready channel carrying the window length write data
// ----------------------------------------------------------------------------
interface maf_cfg_if import maf_pkg::*;;
    logic valid;
    logic ready;
    t_cfg window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

### sv/maf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_div - serial unsigned divider
// restoring division, one quotient bit per cycle
// ----------------------------------------------------------------------------
module maf_div
    import maf_pkg::*;
#(
    parameter int DVD_W = 22,
    parameter int DVS_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_count;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    // shift in the next dividend bit and trial-subtract
    always_comb begin
        rem_sh  = {r_rem, r_quo[DVD_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    assign o_done     = r_busy && (r_count == CNT_W'(DVD_W - 1));
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= '0;
        end else if (r_busy) begin
            r_busy  <= !o_done;
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= rem_sub[DVS_W-1:0];
        end
    end

endmodule

### sv/moving_average_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_filter - simple moving average of signed samples
// circular window store, running sum and a serial divider for the mean
// ----------------------------------------------------------------------------
// usage
//   i_sample : sample requests (valid/ready), one signed 16-bit sample each
//   o_mean   : mean requests (valid/ready), one per sample, in order
//   i_cfg    : window length writes (valid/ready), 0 acts as 1, values above
//              MAX_WINDOW saturate; a write empties the window
// timing
//   a taken sample passes through the read, update, divide and done states
//   before its mean is presented, and the serial divider, one quotient bit
//   per cycle, sets the pace; a new sample is taken only when the sequencer
//   is back in idle
// reset
//   window is all zeros, write position and sum zero, length 8 (or
//   MAX_WINDOW if smaller); per-entry valid bits make unwritten slots read 0
// back pressure
//   the mean sits in an output register; the next sample is accepted while
//   it waits, and the sequencer holds its finished result until it drains
// ----------------------------------------------------------------------------
module moving_average_filter
    import maf_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    maf_sample_if.sink   i_sample,
    maf_cfg_if.sink      i_cfg,
    maf_mean_if.source   o_mean
);

    localparam int IDX_W   = $clog2(MAX_WINDOW);
    localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int LEN_RST = (8 > MAX_WINDOW) ? MAX_WINDOW : 8;

    t_state r_state, n_state;

    // window store and its per-entry valid bits
    t_sample                r_mem [MAX_WINDOW];
    t_sample                r_rd_data;
    logic [MAX_WINDOW-1:0]  r_valid;

    logic [IDX_W-1:0]       r_pos;
    logic [LEN_W-1:0]       r_len;
    logic signed [SUM_W-1:0] r_sum;
    t_sample                r_sample;
    logic                   r_neg;

    t_sample                r_mean;
    logic                   r_out_valid;

    // sequencer controls
    logic                   smp_ready;
    logic                   div_start;
    logic                   out_load;

    logic                   smp_acc;
    logic                   cfg_acc;
    logic [LEN_W-1:0]       cfg_len;
    logic signed [SUM_W-1:0] old_val;
    logic signed [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0]       sum_mag;
    logic [IDX_W:0]         pos_inc;
    logic [IDX_W-1:0]       n_pos;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quo;
    t_sample                quo_lo;

    assign smp_acc = i_sample.valid && i_sample.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;

    // length clamp: zero acts as one, above the store saturates
    always_comb begin
        if (i_cfg.window_length == '0) begin
            cfg_len = LEN_W'(1);
        end else if (int'(i_cfg.window_length) > MAX_WINDOW) begin
            cfg_len = LEN_W'(MAX_WINDOW);
        end else begin
            cfg_len = LEN_W'(i_cfg.window_length);
        end
    end

    // running sum: drop the oldest sample, add the new one
    always_comb begin
        old_val = r_valid[r_pos] ? SUM_W'(r_rd_data) : '0;
        n_sum   = r_sum - old_val + SUM_W'(r_sample);
        sum_mag = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
        pos_inc = {1'b0, r_pos} + (IDX_W+1)'(1);
        n_pos   = (pos_inc >= (IDX_W+1)'(r_len)) ? '0 : pos_inc[IDX_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (smp_acc) n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_DIV;
            ST_DIV:    if (div_done) n_state = ST_DONE;
            ST_DONE:   if (!r_out_valid || o_mean.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        smp_ready = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE:   smp_ready = 1'b1;
            ST_UPDATE: div_start = 1'b1;
            ST_DONE:   out_load  = !r_out_valid || o_mean.ready;
            default:   ;
        endcase
    end

    assign i_sample.ready = smp_ready;
    assign i_cfg.ready    = smp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window state; a length write empties the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
            r_len   <= LEN_W'(LEN_RST);
        end else if (cfg_acc) begin
            r_valid <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
            r_len   <= cfg_len;
        end else if (r_state == ST_UPDATE) begin
            r_valid[r_pos] <= 1'b1;
            r_pos          <= n_pos;
            r_sum          <= n_sum;
        end
    end

    // store: registered read of the oldest slot, write of the new sample
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd_data <= r_mem[r_pos];
        end
        if (r_state == ST_UPDATE) begin
            r_mem[r_pos] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_sample <= i_sample.sample;
        end
        if (div_start) begin
            r_neg <= n_sum[SUM_W-1];
        end
    end

    maf_div #(
        .DVD_W (SUM_W),
        .DVS_W (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag),
        .i_divisor  (r_len),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // quotient magnitude is at most 32768, so the low bits carry it
    assign quo_lo = div_quo[SAMPLE_W-1:0];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_mean.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_mean <= r_neg ? -quo_lo : quo_lo;
        end
    end

    assign o_mean.valid = r_out_valid;
    assign o_mean.mean  = r_mean;

    // write position stays inside the window
    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (IDX_W+1)'(r_pos) < (IDX_W+1)'(r_len))
        else $error("write position outside window");

    // window length stays in range
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) && (int'(r_len) <= MAX_WINDOW))
        else $error("window length out of range");

    // an accepted sample starts the store read
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_acc |=> (r_state == ST_READ))
        else $error("sample accepted without store read");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");

    // a finished mean is never dropped
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("mean load lost");

endmodule
